[rtl/core/enr_pkg.sv]
// ----------------------------------------------------------------------------
// enr_pkg: shared types, wiring tables and mod-26 helpers
// Holds the wheel and reflector permutations, the notch letters, the
// register codes and the small arithmetic used by the front and back ends.
// ----------------------------------------------------------------------------
package enr_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned WHEEL_MAX   = 5;
  localparam int unsigned WHEEL_COUNT = 5;
  localparam int unsigned WHEEL_W     = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 60;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [NUM_LETTERS-1:0][LETTER_W-1:0] perm_t;
  typedef logic [WHEEL_W-1:0] wheel_t;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROTOR_ORDER     = 3'd0,
    REG_RING_SETTINGS   = 3'd1,
    REG_START_POSITIONS = 3'd2,
    REG_PLUG_LOW        = 3'd3,
    REG_PLUG_MID        = 3'd4,
    REG_PLUG_HIGH       = 3'd5
  } cfg_reg_e;

  localparam logic [8:0] ROTOR_ORDER_RESET = 9'd10;

  // One queued letter with the rotor offsets that apply to it
  typedef struct packed {
    letter_t letter;
    letter_t shift_l;
    letter_t shift_m;
    letter_t shift_r;
  } item_t;

  // Settings the substitution path needs from the front end
  typedef struct packed {
    wheel_t wheel_l;
    wheel_t wheel_m;
    wheel_t wheel_r;
    perm_t  plug;
  } path_cfg_t;

  // Turn a 26-letter ASCII string into a letter permutation
  function automatic perm_t str_perm(input logic [8*NUM_LETTERS-1:0] s);
    perm_t p;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      p[i] = letter_t'(s[8*(NUM_LETTERS-1-i) +: 8] - 8'd65);
    end
    return p;
  endfunction

  function automatic perm_t invert(input perm_t p);
    perm_t q;
    q = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      q[p[i]] = letter_t'(i);
    end
    return q;
  endfunction

  function automatic perm_t identity();
    perm_t p;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      p[i] = letter_t'(i);
    end
    return p;
  endfunction

  localparam perm_t WIRING [WHEEL_MAX] = '{
    str_perm("EKMFLGDQVZNTOWYHXUSPAIBRCJ"),
    str_perm("AJDKSIRUXBLHWTMCQGZNPYFVOE"),
    str_perm("BDFHJLCPRTXVZNYEIWGAKMUSQO"),
    str_perm("ESOVPZJAYQUIRHXLNFTGKDCMWB"),
    str_perm("VZBRGITYUPSDNHLXAWMJQOFECK")
  };

  localparam perm_t WIRING_INV [WHEEL_MAX] = '{
    invert(str_perm("EKMFLGDQVZNTOWYHXUSPAIBRCJ")),
    invert(str_perm("AJDKSIRUXBLHWTMCQGZNPYFVOE")),
    invert(str_perm("BDFHJLCPRTXVZNYEIWGAKMUSQO")),
    invert(str_perm("ESOVPZJAYQUIRHXLNFTGKDCMWB")),
    invert(str_perm("VZBRGITYUPSDNHLXAWMJQOFECK"))
  };

  localparam perm_t REFLECTOR = str_perm("YRUHQSLDPXNGOKMIEBFZCWVJAT");

  // Notch sits one letter before the turnover letters R, F, W, K, A
  localparam letter_t NOTCH [WHEEL_MAX] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

  function automatic letter_t red26(input letter_t v);
    return (v >= letter_t'(NUM_LETTERS)) ? letter_t'(v - letter_t'(NUM_LETTERS)) : v;
  endfunction

  function automatic letter_t inc26(input letter_t v);
    return (v == letter_t'(NUM_LETTERS - 1)) ? '0 : letter_t'(v + 1'b1);
  endfunction

  // Both operands below 26
  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(NUM_LETTERS)) begin
      s = s - (LETTER_W+1)'(NUM_LETTERS);
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = ({1'b0, a} + (LETTER_W+1)'(NUM_LETTERS)) - {1'b0, b};
    if (s >= (LETTER_W+1)'(NUM_LETTERS)) begin
      s = s - (LETTER_W+1)'(NUM_LETTERS);
    end
    return s[LETTER_W-1:0];
  endfunction

  // Pass a letter through one wheel at the given offset
  function automatic letter_t rotor_pass(input perm_t p, input letter_t shift,
                                         input letter_t c);
    return sub26(p[add26(c, shift)], shift);
  endfunction

  // Clamp a wheel code to the fitted wheels
  function automatic wheel_t wheel_of(input wheel_t code, input int unsigned count);
    return (code >= wheel_t'(count)) ? wheel_t'(count - 1) : code;
  endfunction

endpackage

[rtl/core/enr_if.sv]
// ----------------------------------------------------------------------------
// enr_if: channel interfaces
// Valid/ready channels for plain letters, cipher letters and register writes.
// ----------------------------------------------------------------------------
interface enr_plain_if import enr_pkg::*;;
  logic    valid;
  logic    ready;
  letter_t plain_letter;

  modport source (output valid, output plain_letter, input ready);
  modport sink   (input valid, input plain_letter, output ready);
endinterface

interface enr_cipher_if import enr_pkg::*;;
  logic    valid;
  logic    ready;
  letter_t cipher_letter;

  modport source (output valid, output cipher_letter, input ready);
  modport sink   (input valid, input cipher_letter, output ready);
endinterface

interface enr_cfg_if import enr_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/enigma_rotor_cipher.sv]
// Throughput: one letter per cycle unless cipher_o stalls, set by the front
// end stepping and the four-stage substitution pipeline plus output register.
// Reset: settings return to wheels I-II-III, rings and positions at A and an
// open plugboard; a known-register write reloads the rotor start positions.
// ----------------------------------------------------------------------------
// enigma_rotor_cipher: three-rotor letter cipher
// Front end steps the rotors, a short queue decouples it from the
// substitution pipeline in the back end.
// ----------------------------------------------------------------------------
module enigma_rotor_cipher import enr_pkg::*; #(
  parameter int unsigned WheelCount = WHEEL_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  enr_plain_if.sink    plain_i,
  enr_cfg_if.sink      cfg_i,
  enr_cipher_if.source cipher_o
);

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  item_t     push_item, pop_item;
  path_cfg_t path_cfg;

  enr_front #(
    .WheelCount (WheelCount)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plain_i      (plain_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item),
    .path_cfg_o   (path_cfg)
  );

  enr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  enr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .path_cfg_i  (path_cfg),
    .cipher_o    (cipher_o)
  );

endmodule

[rtl/core/enr_front.sv]
// ----------------------------------------------------------------------------
// enr_front: register file and rotor stepping
// Holds the settings and rotor positions, steps the rotors for each accepted
// word unless a write coincides, and queues the letter with its three offsets.
// ----------------------------------------------------------------------------
module enr_front import enr_pkg::*; #(
  parameter int unsigned WheelCount = WHEEL_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  enr_plain_if.sink  plain_i,
  enr_cfg_if.sink    cfg_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output item_t      push_item_o,
  output path_cfg_t  path_cfg_o
);

  logic [8:0]  rotor_order_q;
  logic [14:0] ring_q;
  logic [14:0] start_q;
  perm_t       plug_q;
  letter_t     pos_l_q, pos_m_q, pos_r_q;
  letter_t     pos_l_d, pos_m_d, pos_r_d;

  wheel_t      wheel_l, wheel_m, wheel_r;
  logic        mid_notch, right_notch;
  logic        cfg_we, cfg_known, accept;
  logic [14:0] start_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign accept      = plain_i.valid & push_ready_i;

  // Decode wheels and step the rotors
  always_comb begin
    wheel_l     = wheel_of(rotor_order_q[8:6], WheelCount);
    wheel_m     = wheel_of(rotor_order_q[5:3], WheelCount);
    wheel_r     = wheel_of(rotor_order_q[2:0], WheelCount);
    mid_notch   = (pos_m_q == NOTCH[wheel_m]);
    right_notch = (pos_r_q == NOTCH[wheel_r]);
    pos_l_d     = mid_notch ? inc26(pos_l_q) : pos_l_q;
    pos_m_d     = (mid_notch || right_notch) ? inc26(pos_m_q) : pos_m_q;
    pos_r_d     = inc26(pos_r_q);
  end

  // Offsets from the stepped positions and the ring settings
  always_comb begin
    push_item_o.letter  = red26(plain_i.plain_letter);
    push_item_o.shift_l = sub26(pos_l_d, red26(ring_q[14:10]));
    push_item_o.shift_m = sub26(pos_m_d, red26(ring_q[9:5]));
    push_item_o.shift_r = sub26(pos_r_d, red26(ring_q[4:0]));
  end

  assign push_valid_o  = plain_i.valid;
  assign plain_i.ready = push_ready_i;

  assign path_cfg_o.wheel_l = wheel_l;
  assign path_cfg_o.wheel_m = wheel_m;
  assign path_cfg_o.wheel_r = wheel_r;
  assign path_cfg_o.plug    = plug_q;

  // Known index reloads the positions; start value may be the one written now
  always_comb begin
    start_d   = start_q;
    cfg_known = 1'b1;
    case (cfg_i.index)
      REG_START_POSITIONS: start_d = cfg_i.wdata[14:0];
      REG_ROTOR_ORDER, REG_RING_SETTINGS, REG_PLUG_LOW, REG_PLUG_MID,
      REG_PLUG_HIGH: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  // Hold settings and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_order_q <= ROTOR_ORDER_RESET;
      ring_q        <= '0;
      start_q       <= '0;
      plug_q        <= identity();
      pos_l_q       <= '0;
      pos_m_q       <= '0;
      pos_r_q       <= '0;
    end else if (cfg_we) begin
      case (cfg_i.index)
        REG_ROTOR_ORDER:     rotor_order_q  <= cfg_i.wdata[8:0];
        REG_RING_SETTINGS:   ring_q         <= cfg_i.wdata[14:0];
        REG_START_POSITIONS: start_q        <= cfg_i.wdata[14:0];
        REG_PLUG_LOW:        plug_q[11:0]   <= cfg_i.wdata[59:0];
        REG_PLUG_MID:        plug_q[23:12]  <= cfg_i.wdata[59:0];
        REG_PLUG_HIGH:       plug_q[25:24]  <= cfg_i.wdata[9:0];
        default: ;
      endcase
      if (cfg_known) begin
        pos_l_q <= red26(start_d[14:10]);
        pos_m_q <= red26(start_d[9:5]);
        pos_r_q <= red26(start_d[4:0]);
      end
    end else if (accept) begin
      pos_l_q <= pos_l_d;
      pos_m_q <= pos_m_d;
      pos_r_q <= pos_r_d;
    end
  end

endmodule

[rtl/core/enr_queue.sv]
// ----------------------------------------------------------------------------
// enr_queue: two-entry queue between front and back end
// Lets either side stall on its own; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module enr_queue import enr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q < QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= QCNT_W'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= QCNT_W'(count_q - 1'b1);
      end
    end
  end

endmodule

[rtl/core/enr_back.sv]
// ----------------------------------------------------------------------------
// enr_back: substitution pipeline
// Plugboard, three wheels, reflector, wheels in reverse and plugboard again,
// spread over four stages plus the output register.
// ----------------------------------------------------------------------------
module enr_back import enr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  item_t        pop_item_i,
  input  path_cfg_t    path_cfg_i,
  enr_cipher_if.source cipher_o
);

  logic    advance;
  logic    s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  item_t   s1_q, s2_q, s3_q;
  item_t   s1_d, s2_d, s3_d;
  letter_t s4_q, s4_d;
  letter_t out_q, out_d;
  letter_t mid_fwd, mid_bwd;

  // Whole pipeline moves while the output register can take a word
  assign advance     = !out_valid_q || cipher_o.ready;
  assign pop_ready_o = advance;

  // Plugboard in, right wheel forward
  always_comb begin
    s1_d        = pop_item_i;
    s1_d.letter = rotor_pass(WIRING[path_cfg_i.wheel_r], pop_item_i.shift_r,
                             red26(path_cfg_i.plug[pop_item_i.letter]));
  end

  // Middle and left wheels forward
  always_comb begin
    mid_fwd     = rotor_pass(WIRING[path_cfg_i.wheel_m], s1_q.shift_m, s1_q.letter);
    s2_d        = s1_q;
    s2_d.letter = rotor_pass(WIRING[path_cfg_i.wheel_l], s1_q.shift_l, mid_fwd);
  end

  // Reflector, left wheel back
  always_comb begin
    s3_d        = s2_q;
    s3_d.letter = rotor_pass(WIRING_INV[path_cfg_i.wheel_l], s2_q.shift_l,
                             REFLECTOR[s2_q.letter]);
  end

  // Middle and right wheels back
  always_comb begin
    mid_bwd = rotor_pass(WIRING_INV[path_cfg_i.wheel_m], s3_q.shift_m, s3_q.letter);
    s4_d    = rotor_pass(WIRING_INV[path_cfg_i.wheel_r], s3_q.shift_r, mid_bwd);
  end

  // Plugboard out
  assign out_d = red26(path_cfg_i.plug[s4_q]);

  // Stage data
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      out_q <= out_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign cipher_o.valid         = out_valid_q;
  assign cipher_o.cipher_letter = out_q;

endmodule
